### design/rcic_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inode cache table package
// Field widths, command and status codes, and the slot write request shared
// by the inode cache table modules.
// ---------------------------------------------------------------------------
package rcic_pkg;

	localparam int NUMBER_W    = 16;
	localparam int SECTOR_W    = 17;
	localparam int SLOT_W      = 4;
	localparam int LINK_W      = 8;
	localparam int STATUS_W    = 2;
	// Widest slot address and count over the legal parameter ranges.
	localparam int ADDR_MAX_W  = 8;
	localparam int COUNT_MAX_W = 16;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_PUT_FREE = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	// One slot update: address, inode number and new reference count.
	typedef struct packed {
		logic                   en;
		logic [ADDR_MAX_W-1:0]  addr;
		logic [NUMBER_W-1:0]    number;
		logic [COUNT_MAX_W-1:0] count;
	} wr_req_t;

endpackage

### design/rcic_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inode cache slot store
// Slot memory for inode numbers and reference counts with one write and one
// registered read port. Live bits in flops clear every slot at reset.
// ---------------------------------------------------------------------------
module rcic_store #(
	parameter int TABLE_SLOTS = 16,
	parameter int COUNT_BITS  = 8,
	parameter int IDX_W       = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcic_pkg::wr_req_t             wr,
	input  logic [IDX_W-1:0]              rd_addr,
	output logic [rcic_pkg::NUMBER_W-1:0] rd_number,
	output logic [COUNT_BITS-1:0]         rd_count
);

	logic [rcic_pkg::NUMBER_W-1:0] number_mem [TABLE_SLOTS];
	logic [COUNT_BITS-1:0]         count_mem  [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0]        live_q;
	logic [IDX_W-1:0]              wr_addr;
	logic [rcic_pkg::NUMBER_W-1:0] number_s1;
	logic [COUNT_BITS-1:0]         count_s1;
	logic                          live_s1;

	assign wr_addr = IDX_W'(wr.addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (wr.en) begin
			live_q[wr_addr] <= (wr.count != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			number_mem[wr_addr] <= wr.number;
			count_mem[wr_addr]  <= COUNT_BITS'(wr.count);
		end
		number_s1 <= number_mem[rd_addr];
		count_s1  <= count_mem[rd_addr];
		live_s1   <= live_q[rd_addr];
	end

	// A slot that is not live reads as free.
	assign rd_number = number_s1;
	assign rd_count  = live_s1 ? count_s1 : '0;

endmodule

### design/rcic_sector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inode sector calculator
// Two-stage pipeline: inode number over inodes per sector by a reciprocal
// multiply, then the inode zone start is added.
// ---------------------------------------------------------------------------
module rcic_sector #(
	parameter int INODES_PER_SECTOR = 8
) (
	input  logic                          clk,
	input  logic [rcic_pkg::NUMBER_W-1:0] number,
	input  logic [rcic_pkg::NUMBER_W-1:0] zone_start,
	output logic [rcic_pkg::SECTOR_W-1:0] sector
);

	localparam int LOG_D  = (INODES_PER_SECTOR > 1) ? $clog2(INODES_PER_SECTOR) : 0;
	localparam int SHIFT  = rcic_pkg::NUMBER_W + LOG_D;
	localparam int PROD_W = 2 * rcic_pkg::NUMBER_W + 1;
	// Rounded-up reciprocal; exact quotient for every 16-bit dividend.
	localparam int RECIP  = ((2 ** SHIFT) + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR;

	logic [PROD_W-1:0]             prod_s1;
	logic [rcic_pkg::NUMBER_W-1:0] quot;
	logic [rcic_pkg::SECTOR_W-1:0] sector_s2;

	assign quot = rcic_pkg::NUMBER_W'(prod_s1 >> SHIFT);

	always_ff @(posedge clk) begin
		prod_s1   <= PROD_W'(number) * PROD_W'(RECIP);
		sector_s2 <= rcic_pkg::SECTOR_W'(zone_start) + rcic_pkg::SECTOR_W'(quot);
	end

	assign sector = sector_s2;

endmodule

### design/refcounted_inode_cache_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reference-counted inode cache table
// Slot table of resident inodes with reference counts: get looks up or
// claims a slot, put releases one and reports write-back and disk free.
// ---------------------------------------------------------------------------
// A get request walks the slot memory one slot per cycle through a single
// number comparator, noting the first live slot holding the requested inode
// and the first free slot; it then decides and updates one slot. A put reads
// the named slot once. The block takes one request at a time: req_stall is
// high from the transfer until the response is loaded into the output
// register, which may still hold an earlier response while a new request
// is being worked on. The disk sector of a newly claimed inode is
// inode_zone_start plus the inode number divided by INODES_PER_SECTOR, formed
// by a two-stage reciprocal multiply that runs alongside the scan.
// inode_zone_start is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, as the block itself does not enforce
// this. Every response field that has no meaning for the command or status
// is zero.
// ---------------------------------------------------------------------------
module refcounted_inode_cache_table #(
	parameter int TABLE_SLOTS       = 16,
	parameter int INODES_PER_SECTOR = 8,
	parameter int COUNT_BITS        = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [rcic_pkg::NUMBER_W-1:0] cfg_wr_data,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          command,
	input  logic [rcic_pkg::NUMBER_W-1:0] inode_number,
	input  logic [rcic_pkg::SLOT_W-1:0]   slot_index,
	input  logic signed [rcic_pkg::LINK_W-1:0] link_count,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [rcic_pkg::STATUS_W-1:0] status,
	output logic [rcic_pkg::SLOT_W-1:0]   slot,
	output logic                          hit,
	output logic                          read_from_disk,
	output logic [rcic_pkg::SECTOR_W-1:0] disk_sector,
	output logic                          last_release,
	output logic                          free_on_disk,
	output logic [rcic_pkg::NUMBER_W-1:0] released_number
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_GET_DEC,
		ST_PUT_RD,
		ST_PUT_DEC
	} state_t;

	state_t                        state_q;
	logic [rcic_pkg::NUMBER_W-1:0] zone_q;

	// request held for the duration of the operation
	rcic_pkg::cmd_t                cmd_q;
	logic [rcic_pkg::NUMBER_W-1:0] num_q;
	logic [rcic_pkg::SLOT_W-1:0]   sidx_q;
	logic                          in_range_q;
	logic                          link_le_zero_q;

	// scan bookkeeping
	logic [IDX_W-1:0]              addr_q;
	logic                          tag_vld_s1;
	logic [IDX_W-1:0]              tag_idx_s1;
	logic                          found_q;
	logic [IDX_W-1:0]              found_idx_q;
	logic [COUNT_BITS-1:0]         found_cnt_q;
	logic                          free_q;
	logic [IDX_W-1:0]              free_idx_q;

	// store and sector pipeline
	rcic_pkg::wr_req_t             st_wr;
	logic [rcic_pkg::NUMBER_W-1:0] rd_number;
	logic [COUNT_BITS-1:0]         rd_count;
	logic [rcic_pkg::SECTOR_W-1:0] sector;

	// shared count adder and number comparator
	logic [COUNT_BITS-1:0]         cnt_op;
	logic [COUNT_BITS-1:0]         cnt_sum;
	logic                          num_match;

	// response registers and next values
	logic                          rsp_valid_q;
	logic                          rsp_load;
	rcic_pkg::status_t             status_q,   status_d;
	logic [rcic_pkg::SLOT_W-1:0]   slot_q,     slot_d;
	logic                          hit_q,      hit_d;
	logic                          read_q,     read_d;
	logic [rcic_pkg::SECTOR_W-1:0] sector_q,   sector_d;
	logic                          last_q,     last_d;
	logic                          free_dsk_q, free_dsk_d;
	logic [rcic_pkg::NUMBER_W-1:0] rel_num_q,  rel_num_d;

	rcic_store #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.COUNT_BITS  (COUNT_BITS),
		.IDX_W       (IDX_W)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (st_wr),
		.rd_addr   (addr_q),
		.rd_number (rd_number),
		.rd_count  (rd_count)
	);

	// Runs continuously from the held inode number; settled well before decide.
	rcic_sector #(
		.INODES_PER_SECTOR (INODES_PER_SECTOR)
	) u_sector (
		.clk        (clk),
		.number     (num_q),
		.zone_start (zone_q),
		.sector     (sector)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_load  = !rsp_valid_q || !rsp_stall;

	// One comparator checks the slot read back in this cycle.
	assign num_match = (rd_number == num_q);

	// One adder: increment for a get hit, decrement for a put.
	always_comb begin
		if (cmd_q == rcic_pkg::CMD_GET) begin
			cnt_op  = found_cnt_q;
			cnt_sum = cnt_op + COUNT_BITS'(1);
		end else begin
			cnt_op  = rd_count;
			cnt_sum = cnt_op - COUNT_BITS'(1);
		end
	end

	// Decide the outcome and the slot update in the decide states.
	always_comb begin
		status_d   = rcic_pkg::STAT_OK;
		slot_d     = '0;
		hit_d      = 1'b0;
		read_d     = 1'b0;
		sector_d   = '0;
		last_d     = 1'b0;
		free_dsk_d = 1'b0;
		rel_num_d  = '0;
		st_wr      = '0;
		unique case (state_q)
			ST_GET_DEC: begin
				if (found_q) begin
					slot_d = rcic_pkg::SLOT_W'(found_idx_q);
					if (found_cnt_q == COUNT_MAX) begin
						status_d = rcic_pkg::STAT_OVERFLOW;
					end else begin
						hit_d        = 1'b1;
						st_wr.en     = rsp_load;
						st_wr.addr   = rcic_pkg::ADDR_MAX_W'(found_idx_q);
						st_wr.number = num_q;
						st_wr.count  = rcic_pkg::COUNT_MAX_W'(cnt_sum);
					end
				end else if (free_q) begin
					slot_d       = rcic_pkg::SLOT_W'(free_idx_q);
					read_d       = 1'b1;
					sector_d     = sector;
					st_wr.en     = rsp_load;
					st_wr.addr   = rcic_pkg::ADDR_MAX_W'(free_idx_q);
					st_wr.number = num_q;
					st_wr.count  = rcic_pkg::COUNT_MAX_W'(1);
				end else begin
					status_d = rcic_pkg::STAT_FULL;
				end
			end
			ST_PUT_DEC: begin
				slot_d = sidx_q;
				if (!in_range_q || rd_count == '0) begin
					status_d = rcic_pkg::STAT_PUT_FREE;
				end else begin
					rel_num_d    = rd_number;
					last_d       = (cnt_sum == '0);
					free_dsk_d   = (cnt_sum == '0) && link_le_zero_q;
					st_wr.en     = rsp_load;
					st_wr.addr   = rcic_pkg::ADDR_MAX_W'(addr_q);
					// clear the number when the slot goes free
					st_wr.number = (cnt_sum == '0) ? '0 : rd_number;
					st_wr.count  = rcic_pkg::COUNT_MAX_W'(cnt_sum);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, scan flags and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zone_q      <= '0;
			rsp_valid_q <= 1'b0;
			tag_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			addr_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				zone_q <= cfg_wr_data;
			end
			// raise valid when a decide step loads, drop it once the response is taken
			if ((state_q == ST_GET_DEC || state_q == ST_PUT_DEC) && rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			tag_vld_s1 <= (state_q == ST_SCAN);
			// fold in the slot that came back from the store
			if (tag_vld_s1) begin
				if (!found_q && rd_count != '0 && num_match) begin
					found_q <= 1'b1;
				end
				if (!free_q && rd_count == '0) begin
					free_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						found_q <= 1'b0;
						free_q  <= 1'b0;
						if (command == rcic_pkg::CMD_PUT) begin
							// an out-of-range slot reads slot zero, result ignored
							addr_q  <= (32'(slot_index) < 32'(TABLE_SLOTS)) ?
								IDX_W'(slot_index) : '0;
							state_q <= ST_PUT_RD;
						end else begin
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_GET_DEC;
				end
				ST_PUT_RD: begin
					state_q <= ST_PUT_DEC;
				end
				ST_GET_DEC, ST_PUT_DEC: begin
					// hold until the output register is free
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, scan hits and response payload.
	always_ff @(posedge clk) begin
		tag_idx_s1 <= addr_q;
		if (state_q == ST_IDLE && req_valid) begin
			cmd_q          <= rcic_pkg::cmd_t'(command);
			num_q          <= inode_number;
			sidx_q         <= slot_index;
			in_range_q     <= (32'(slot_index) < 32'(TABLE_SLOTS));
			link_le_zero_q <= (link_count == '0) || link_count[rcic_pkg::LINK_W-1];
		end
		if (tag_vld_s1) begin
			if (!found_q && rd_count != '0 && num_match) begin
				found_idx_q <= tag_idx_s1;
				found_cnt_q <= rd_count;
			end
			if (!free_q && rd_count == '0) begin
				free_idx_q <= tag_idx_s1;
			end
		end
		if ((state_q == ST_GET_DEC || state_q == ST_PUT_DEC) && rsp_load) begin
			status_q   <= status_d;
			slot_q     <= slot_d;
			hit_q      <= hit_d;
			read_q     <= read_d;
			sector_q   <= sector_d;
			last_q     <= last_d;
			free_dsk_q <= free_dsk_d;
			rel_num_q  <= rel_num_d;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign hit             = hit_q;
	assign read_from_disk  = read_q;
	assign disk_sector     = sector_q;
	assign last_release    = last_q;
	assign free_on_disk    = free_dsk_q;
	assign released_number = rel_num_q;

`ifndef SYNTHESIS
	a_wr_only_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr.en |-> (state_q == ST_GET_DEC || state_q == ST_PUT_DEC))
		else $error("slot write outside a decide state");

	a_transfer_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_SCAN || state_q == ST_PUT_RD))
		else $error("accepted request did not start an operation");

	a_rsp_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |->
			($past(state_q) == ST_GET_DEC || $past(state_q) == ST_PUT_DEC))
		else $error("response raised without a decide step");

	a_hit_or_claim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(hit_q && read_q) && (!free_dsk_q || last_q))
		else $error("inconsistent response flags");
`endif

endmodule

### tb/inode_cache_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inode cache table checker
// Watches the configuration, request and response channels of the inode
// cache table, keeps its own copy of the slot table, and compares every
// response transfer field by field with the oldest predicted response.
// ---------------------------------------------------------------------------
module inode_cache_checker #(
	parameter int TABLE_SLOTS       = 16,
	parameter int INODES_PER_SECTOR = 8,
	parameter int COUNT_BITS        = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rcic_pkg::NUMBER_W-1:0] cfg_wr_data,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic                          command,
	input  logic [rcic_pkg::NUMBER_W-1:0] inode_number,
	input  logic [rcic_pkg::SLOT_W-1:0]   slot_index,
	input  logic signed [rcic_pkg::LINK_W-1:0] link_count,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic [rcic_pkg::STATUS_W-1:0] status,
	input  logic [rcic_pkg::SLOT_W-1:0]   slot,
	input  logic                          hit,
	input  logic                          read_from_disk,
	input  logic [rcic_pkg::SECTOR_W-1:0] disk_sector,
	input  logic                          last_release,
	input  logic                          free_on_disk,
	input  logic [rcic_pkg::NUMBER_W-1:0] released_number,
	output int                            fail_count,
	output int                            waiting_count
);
	import rcic_pkg::*;

	localparam int unsigned COUNT_LIMIT = (1 << COUNT_BITS) - 1;

	typedef struct packed {
		status_t               status;
		logic [SLOT_W-1:0]     slot;
		logic                  hit;
		logic                  read_from_disk;
		logic [SECTOR_W-1:0]   disk_sector;
		logic                  last_release;
		logic                  free_on_disk;
		logic [NUMBER_W-1:0]   released_number;
	} inode_reply_t;

	logic [NUMBER_W-1:0] cached_number [TABLE_SLOTS];
	int unsigned         ref_count     [TABLE_SLOTS];
	logic [NUMBER_W-1:0] zone_start;
	inode_reply_t        pending_replies [$];
	inode_reply_t        want;
	int                  errors;
	int                  s;

	// Apply one request to the shadow table and return the response it owes.
	function automatic inode_reply_t cache_response(cmd_t cmd, logic [NUMBER_W-1:0] num,
			logic [SLOT_W-1:0] sidx, logic signed [LINK_W-1:0] links);
		inode_reply_t r;
		int match;
		int vacant;
		r = '0;
		match = -1;
		vacant = -1;
		if (cmd == CMD_GET) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (match < 0 && ref_count[i] != 0 && cached_number[i] == num)
					match = i;
				if (vacant < 0 && ref_count[i] == 0)
					vacant = i;
			end
			if (match >= 0) begin
				r.slot = SLOT_W'(match);
				if (ref_count[match] >= COUNT_LIMIT) begin
					r.status = STAT_OVERFLOW;
				end else begin
					ref_count[match]++;
					r.hit = 1'b1;
				end
			end else if (vacant >= 0) begin
				cached_number[vacant] = num;
				ref_count[vacant] = 1;
				r.slot = SLOT_W'(vacant);
				r.read_from_disk = 1'b1;
				r.disk_sector = SECTOR_W'(zone_start) + SECTOR_W'(num / INODES_PER_SECTOR);
			end else begin
				r.status = STAT_FULL;
			end
		end else begin
			r.slot = sidx;
			if (int'(sidx) >= TABLE_SLOTS || ref_count[sidx] == 0) begin
				r.status = STAT_PUT_FREE;
			end else begin
				r.released_number = cached_number[sidx];
				ref_count[sidx]--;
				if (ref_count[sidx] == 0) begin
					r.last_release = 1'b1;
					r.free_on_disk = (links <= 0);
					cached_number[sidx] = '0;
				end
			end
		end
		return r;
	endfunction

	// Four-state compare so an unknown output bit counts as a mismatch.
	task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (s = 0; s < TABLE_SLOTS; s++) begin
				cached_number[s] = '0;
				ref_count[s] = 0;
			end
			zone_start = '0;
			pending_replies.delete();
			errors = 0;
			fail_count <= 0;
			waiting_count <= 0;
		end else begin
			if (cfg_wr_en)
				zone_start = cfg_wr_data;
			if (req_valid && !req_stall)
				pending_replies.push_back(cache_response(cmd_t'(command), inode_number,
					slot_index, link_count));
			if (rsp_valid && !rsp_stall) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: response transfer with no request pending", $time);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					check_field("status", want.status, status);
					check_field("slot", want.slot, slot);
					check_field("hit", want.hit, hit);
					check_field("read_from_disk", want.read_from_disk, read_from_disk);
					check_field("disk_sector", want.disk_sector, disk_sector);
					check_field("last_release", want.last_release, last_release);
					check_field("free_on_disk", want.free_on_disk, free_on_disk);
					check_field("released_number", want.released_number, released_number);
				end
			end
			fail_count <= errors;
			waiting_count <= pending_replies.size();
		end
	end

endmodule

### tb/tb_refcounted_inode_cache_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Inode cache table testbench
// Drives get and put requests into the inode cache table under random
// sender gaps and receiver stalls, changes the inode zone start between
// phases, and reports the verdict of the checker beside the block.
// ---------------------------------------------------------------------------
module tb_refcounted_inode_cache_table;
	import rcic_pkg::*;

	localparam int SLOTS          = 16;
	localparam int PER_SECTOR     = 8;
	localparam int CNT_BITS       = 8;
	localparam int TARGET_ITEMS   = 1800;
	localparam int BURST_ITEMS    = 40;
	localparam int POOL_SIZE      = 24;
	// Allow for a get, the longest sender gap and the longest receiver stall,
	// then leave a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [NUMBER_W-1:0]    cfg_wr_data = '0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	logic                   command = 1'b0;
	logic [NUMBER_W-1:0]    inode_number = '0;
	logic [SLOT_W-1:0]      slot_index = '0;
	logic signed [LINK_W-1:0] link_count = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	logic [STATUS_W-1:0]    status;
	logic [SLOT_W-1:0]      slot;
	logic                   hit;
	logic                   read_from_disk;
	logic [SECTOR_W-1:0]    disk_sector;
	logic                   last_release;
	logic                   free_on_disk;
	logic [NUMBER_W-1:0]    released_number;

	int                     fail_count;
	int                     waiting_count;
	int                     items_sent = 0;
	int                     quiet_cycles = 0;
	int                     stall_hold = 0;
	// Idling switches: when low, that side runs flat out.
	logic                   req_idle_on = 1'b1;
	logic                   rsp_idle_on = 1'b1;
	// Slot of the most recent get that hit or claimed, used to release it again.
	logic [SLOT_W-1:0]      hot_slot = '0;
	logic [NUMBER_W-1:0]    number_pool [POOL_SIZE];

	always #2 clk = ~clk;

	refcounted_inode_cache_table #(
		.TABLE_SLOTS      (SLOTS),
		.INODES_PER_SECTOR(PER_SECTOR),
		.COUNT_BITS       (CNT_BITS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.command        (command),
		.inode_number   (inode_number),
		.slot_index     (slot_index),
		.link_count     (link_count),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.slot           (slot),
		.hit            (hit),
		.read_from_disk (read_from_disk),
		.disk_sector    (disk_sector),
		.last_release   (last_release),
		.free_on_disk   (free_on_disk),
		.released_number(released_number)
	);

	inode_cache_checker #(
		.TABLE_SLOTS      (SLOTS),
		.INODES_PER_SECTOR(PER_SECTOR),
		.COUNT_BITS       (CNT_BITS)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.command        (command),
		.inode_number   (inode_number),
		.slot_index     (slot_index),
		.link_count     (link_count),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.slot           (slot),
		.hit            (hit),
		.read_from_disk (read_from_disk),
		.disk_sector    (disk_sector),
		.last_release   (last_release),
		.free_on_disk   (free_on_disk),
		.released_number(released_number),
		.fail_count     (fail_count),
		.waiting_count  (waiting_count)
	);

	// Receiver stall: short bursts mostly, an occasional long one, and
	// low stretches in between. With idling off, never stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_hold = 0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else if (rsp_stall || !rsp_idle_on) begin
			rsp_stall <= 1'b0;
			stall_hold = rsp_idle_on ? $urandom_range(0, 12) : 0;
		end else begin
			rsp_stall <= 1'b1;
			stall_hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(10, 60);
		end
	end

	// Track the slot a get landed in so the hammer phase can release it.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && (hit || read_from_disk))
			hot_slot <= slot;
	end

	// Watchdog: end the run when no transfer happens on either channel for
	// too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Sender gap before an item: none most of the time, a few cycles often,
	// a long pause now and then.
	function automatic int pick_gap();
		int roll;
		if (!req_idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly reuse a small set of numbers so gets hit; sometimes pick fresh.
	function automatic logic [NUMBER_W-1:0] pick_number();
		if ($urandom_range(0, 99) < 75)
			return number_pool[$urandom_range(0, POOL_SIZE - 1)];
		return NUMBER_W'($urandom);
	endfunction

	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			number_pool[i] = NUMBER_W'($urandom);
		// keep the extremes in play
		number_pool[0] = '0;
		number_pool[1] = '1;
	endtask

	// Present one request and hold it until the transfer happens. Valid stays
	// high into the next item when there is no gap.
	task automatic issue_request(input cmd_t cmd, input logic [NUMBER_W-1:0] num,
			input logic [SLOT_W-1:0] sidx, input logic signed [LINK_W-1:0] links);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= cmd;
		inode_number <= num;
		slot_index <= sidx;
		link_count <= links;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
		items_sent++;
	endtask

	task automatic get_inode(input logic [NUMBER_W-1:0] num);
		issue_request(CMD_GET, num, SLOT_W'($urandom), LINK_W'($urandom));
	endtask

	task automatic put_slot(input logic [SLOT_W-1:0] sidx, input logic signed [LINK_W-1:0] links);
		issue_request(CMD_PUT, NUMBER_W'($urandom), sidx, links);
	endtask

	// Stop sending and hold until every predicted response has come back.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (waiting_count != 0);
	endtask

	// Write the zone start; only called with the block idle.
	task automatic write_zone(input logic [NUMBER_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int burst;
		int get_pct;
		logic [NUMBER_W-1:0] hog_number;

		refresh_pool();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the zone start at its top so sectors are largest.
		write_zone('1);
		get_inode('0);                // claim slot 0 for inode zero
		get_inode('0);                // inode zero in a live slot hits
		get_inode('1);                // largest inode number
		put_slot(4'd0, 8'sd5);        // count drops but slot stays live
		put_slot(4'd0, 8'sd0);        // last release, zero links: free on disk
		put_slot(4'd0, -8'sd128);     // slot now free
		put_slot(4'd15, 8'sd127);     // never claimed
		put_slot(4'd1, 8'sd127);      // last release, links remain
		for (int k = 0; k < SLOTS; k++)
			get_inode(NUMBER_W'(k * 4099 + 3));
		get_inode(16'h1234);          // every slot live: table full

		// Empty the table again, then hammer one inode past the count limit.
		drain();
		write_zone('0);
		for (int k = 0; k < SLOTS; k++)
			put_slot(SLOT_W'(k), LINK_W'($urandom));
		hog_number = NUMBER_W'($urandom);
		for (int k = 0; k < (1 << CNT_BITS) + 2; k++)
			get_inode(hog_number);
		drain();
		for (int k = 0; k < (1 << CNT_BITS) + 2; k++)
			put_slot(hot_slot, LINK_W'($urandom));

		// Random bursts with varying get/put mix, idling and zone start.
		burst = 0;
		while (items_sent < TARGET_ITEMS) begin
			burst++;
			if (burst % 4 == 0) begin
				drain();
				case (burst % 16)
					0:       write_zone('1);
					4:       write_zone('0);
					8:       write_zone(16'h8000);
					default: write_zone(NUMBER_W'($urandom));
				endcase
			end
			if (burst % 7 == 0)
				refresh_pool();
			req_idle_on <= ($urandom_range(0, 4) != 0);
			rsp_idle_on <= ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 3))
				0:       get_pct = 30;
				1:       get_pct = 50;
				2:       get_pct = 70;
				default: get_pct = 90;
			endcase
			// Now and then release every slot once to open room.
			if (burst % 5 == 0) begin
				for (int k = 0; k < SLOTS; k++)
					put_slot(SLOT_W'(k), LINK_W'($urandom));
			end
			for (int n = 0; n < BURST_ITEMS; n++) begin
				if ($urandom_range(0, 99) < get_pct)
					get_inode(pick_number());
				else
					put_slot(SLOT_W'($urandom), LINK_W'($urandom));
			end
		end

		// Drop valid, wait for every response, then let the block settle.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### refcounted_inode_cache_table.f
design/rcic_pkg.sv
design/rcic_store.sv
design/rcic_sector.sv
design/refcounted_inode_cache_table.sv
tb/inode_cache_checker.sv
tb/tb_refcounted_inode_cache_table.sv
